@@ hdl/tsntp_pkg.sv @@
// Fixed-point constants and widths for the two-sided normal tail probability pipeline.
// Standalone; used by two_sided_normal_tail_probability_top.
package tsntp_pkg;

	localparam int IN_FRAC  = 10;
	localparam int OUT_FRAC = 24;
	localparam int Z_W      = 16;
	localparam int P_W      = OUT_FRAC + 1;

	localparam int MAG_W = Z_W + 1;
	localparam int PR_W  = MAG_W + 32;
	localparam int A_W   = 35;
	localparam int D_W   = 34;
	localparam int Y_W   = 32;
	localparam int T_W   = 33;
	localparam int S_W   = 36;
	localparam int ACC_W = 35;
	localparam int V_W   = 34;
	localparam int RCP_W = 35;

	localparam int DIV_BITS   = 3;
	localparam int DIV_STAGES = T_W / DIV_BITS;
	localparam int POLY_STEPS = 5;
	localparam int TERMS      = 10;
	localparam int HALVINGS   = 6;
	localparam int RCP_SH     = 34;
	localparam int OUT_SH     = 32 - OUT_FRAC;

	localparam int LAT = 4 + DIV_STAGES + 2 * POLY_STEPS + 3 * TERMS + 2 * HALVINGS + 2;

	localparam logic [63:0] ONE_Q32 = 64'd1 << 32;
	localparam logic [63:0] HALF    = 64'd1 << 31;
	localparam logic [63:0] A_LIM   = 64'd6 << 32;
	localparam logic [63:0] RND_IN  = 64'd1 << (IN_FRAC - 1);
	localparam logic [63:0] RND_EXP = 64'd1 << (HALVINGS - 1);
	localparam logic [63:0] RND_OUT = (OUT_SH > 0) ? (64'd1 << (OUT_SH - 1)) : 64'd0;
	localparam logic [63:0] P_ONE   = 64'd1 << OUT_FRAC;

	localparam logic [63:0] INV_SQRT2 =
		((64'd707106781 << 32) + 64'd500000000) / 64'd1000000000;
	localparam logic [63:0] COEF_P = ((64'd3275911 << 32) + 64'd5000000) / 64'd10000000;
	localparam logic [63:0] MAG_A1 =
		((64'd254829592 << 32) + 64'd500000000) / 64'd1000000000;
	localparam logic [63:0] MAG_A2 =
		((64'd284496736 << 32) + 64'd500000000) / 64'd1000000000;
	localparam logic [63:0] MAG_A3 =
		((64'd1421413741 << 32) + 64'd500000000) / 64'd1000000000;
	localparam logic [63:0] MAG_A4 =
		((64'd1453152027 << 32) + 64'd500000000) / 64'd1000000000;
	localparam logic [63:0] MAG_A5 =
		((64'd1061405429 << 32) + 64'd500000000) / 64'd1000000000;

	localparam logic signed [S_W-1:0] COEF_A1 = S_W'(MAG_A1);
	localparam logic signed [S_W-1:0] COEF_A2 = -S_W'(MAG_A2);
	localparam logic signed [S_W-1:0] COEF_A3 = S_W'(MAG_A3);
	localparam logic signed [S_W-1:0] COEF_A4 = -S_W'(MAG_A4);
	localparam logic signed [S_W-1:0] COEF_A5 = S_W'(MAG_A5);

	function automatic logic signed [S_W-1:0] poly_coef(input int step);
		logic signed [S_W-1:0] c;
		case (step)
			0: c = COEF_A4;
			1: c = COEF_A3;
			2: c = COEF_A2;
			3: c = COEF_A1;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

@@ hdl/two_sided_normal_tail_probability_top.sv @@
// Two-sided normal tail probability erfc(|z|/sqrt2) in fixed point, fully pipelined.
// Depends on tsntp_pkg for widths, coefficients and stage counts.
// Throughput one beat per cycle unless a valid output beat is stalled, through the stage
// chain (long division 3 bits a stage, Horner, Taylor, squarings).
// A stalled output beat freezes the whole pipeline; in_stall follows it in the same cycle.
// Reset (arst_n low, asynchronous) clears all valid bits; data registers are not reset.
module two_sided_normal_tail_probability_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [tsntp_pkg::Z_W-1:0] z_score,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tsntp_pkg::P_W-1:0]       tail_probability
);

	localparam int DN  = tsntp_pkg::DIV_STAGES;
	localparam int PN  = tsntp_pkg::POLY_STEPS;
	localparam int TN  = tsntp_pkg::TERMS;
	localparam int HN  = tsntp_pkg::HALVINGS;
	localparam int LAT = tsntp_pkg::LAT;
	localparam int M_W = (tsntp_pkg::S_W - 1) + tsntp_pkg::T_W;

	logic           adv;
	logic [LAT:1]   vld_s;

	assign adv       = !(vld_s[LAT] && out_stall);
	assign in_stall  = !adv;
	assign out_valid = vld_s[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-1:1], in_valid};
		end
	end

	// stage 1-4: |z|, a = |z|/sqrt2, d = 1 + p*a, y = a*a/64
	logic [tsntp_pkg::MAG_W-1:0] zx, mag;
	logic [tsntp_pkg::PR_W-1:0]  prod_s1, afull;
	logic [tsntp_pkg::A_W-1:0]   a_s2;
	logic                        big_s2, big_s3;
	logic [tsntp_pkg::A_W+31:0]  pa_s3, pa_r;
	logic [2*tsntp_pkg::A_W-1:0] aa_s3, x_r;
	logic [tsntp_pkg::D_W-1:0]   d_c;

	assign zx    = {z_score[tsntp_pkg::Z_W-1], z_score};
	assign mag   = zx[tsntp_pkg::MAG_W-1] ? (~zx + tsntp_pkg::MAG_W'(1)) : zx;
	assign afull = (prod_s1 + tsntp_pkg::PR_W'(tsntp_pkg::RND_IN)) >> tsntp_pkg::IN_FRAC;
	assign pa_r  = (pa_s3 + (tsntp_pkg::A_W+32)'(tsntp_pkg::HALF)) >> 32;
	assign x_r   = (aa_s3 + (2*tsntp_pkg::A_W)'(tsntp_pkg::HALF)) >> 32;
	assign d_c   = tsntp_pkg::D_W'(pa_r) + tsntp_pkg::D_W'(tsntp_pkg::ONE_Q32);

	logic [tsntp_pkg::D_W-1:0] dv_rem_s [0:DN];
	logic [tsntp_pkg::D_W-1:0] dv_d_s   [0:DN];
	logic [tsntp_pkg::T_W-1:0] dv_quo_s [0:DN];
	logic [tsntp_pkg::T_W-1:0] dv_nlo_s [0:DN];
	logic [tsntp_pkg::Y_W-1:0] dv_y_s   [0:DN];
	logic                      dv_big_s [0:DN];

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1     <= mag * tsntp_pkg::INV_SQRT2[31:0];
			a_s2        <= afull[tsntp_pkg::A_W-1:0];
			big_s2      <= (64'(afull) >= tsntp_pkg::A_LIM);
			pa_s3       <= tsntp_pkg::COEF_P[31:0] * a_s2;
			aa_s3       <= a_s2 * a_s2;
			big_s3      <= big_s2;
			dv_rem_s[0] <= tsntp_pkg::D_W'(1) << 31;
			dv_d_s[0]   <= d_c;
			dv_quo_s[0] <= '0;
			dv_nlo_s[0] <= tsntp_pkg::T_W'(d_c >> 1);
			dv_y_s[0]   <= tsntp_pkg::Y_W'((x_r + (2*tsntp_pkg::A_W)'(tsntp_pkg::RND_EXP)) >> HN);
			dv_big_s[0] <= big_s3;
		end
	end

	// t = floor((2^64 + d/2) / d), restoring division
	for (genvar j = 1; j <= DN; j++) begin : g_div
		logic [tsntp_pkg::D_W-1:0] rem_c;
		logic [tsntp_pkg::T_W-1:0] quo_c, nlo_c;
		logic [tsntp_pkg::D_W:0]   trial;

		always_comb begin
			rem_c = dv_rem_s[j-1];
			quo_c = dv_quo_s[j-1];
			nlo_c = dv_nlo_s[j-1];
			trial = '0;
			for (int b = 0; b < tsntp_pkg::DIV_BITS; b++) begin
				trial = {rem_c, nlo_c[tsntp_pkg::T_W-1]};
				nlo_c = nlo_c << 1;
				if (trial >= {1'b0, dv_d_s[j-1]}) begin
					rem_c = tsntp_pkg::D_W'(trial - {1'b0, dv_d_s[j-1]});
					quo_c = {quo_c[tsntp_pkg::T_W-2:0], 1'b1};
				end else begin
					rem_c = trial[tsntp_pkg::D_W-1:0];
					quo_c = {quo_c[tsntp_pkg::T_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s[j] <= rem_c;
				dv_quo_s[j] <= quo_c;
				dv_nlo_s[j] <= nlo_c;
				dv_d_s[j]   <= dv_d_s[j-1];
				dv_y_s[j]   <= dv_y_s[j-1];
				dv_big_s[j] <= dv_big_s[j-1];
			end
		end
	end

	// Horner polynomial in t
	logic signed [tsntp_pkg::S_W-1:0] hn_s_s   [1:PN];
	logic [tsntp_pkg::T_W-1:0]        hn_t_s   [1:PN];
	logic [tsntp_pkg::Y_W-1:0]        hn_y_s   [1:PN];
	logic                             hn_big_s [1:PN];

	for (genvar h = 0; h < PN; h++) begin : g_poly
		logic signed [tsntp_pkg::S_W-1:0] s_in, sv;
		logic [tsntp_pkg::T_W-1:0]        t_in;
		logic [tsntp_pkg::Y_W-1:0]        y_in;
		logic                             big_in;
		logic [tsntp_pkg::S_W-2:0]        s_mag;
		logic [M_W-1:0]                   m_s, r_c;
		logic                             neg_s, big_s;
		logic [tsntp_pkg::T_W-1:0]        t_s;
		logic [tsntp_pkg::Y_W-1:0]        y_s;

		if (h == 0) begin : g_first
			assign s_in   = tsntp_pkg::COEF_A5;
			assign t_in   = dv_quo_s[DN];
			assign y_in   = dv_y_s[DN];
			assign big_in = dv_big_s[DN];
		end else begin : g_next
			assign s_in   = hn_s_s[h];
			assign t_in   = hn_t_s[h];
			assign y_in   = hn_y_s[h];
			assign big_in = hn_big_s[h];
		end

		assign s_mag = s_in[tsntp_pkg::S_W-1] ? (tsntp_pkg::S_W-1)'(-s_in)
		                                      : (tsntp_pkg::S_W-1)'(s_in);
		assign r_c   = (m_s + M_W'(tsntp_pkg::HALF)) >> 32;
		assign sv    = neg_s ? -$signed({1'b0, r_c[tsntp_pkg::S_W-2:0]})
		                     : $signed({1'b0, r_c[tsntp_pkg::S_W-2:0]});

		always_ff @(posedge clk) begin
			if (adv) begin
				m_s           <= s_mag * t_in;
				neg_s         <= s_in[tsntp_pkg::S_W-1];
				t_s           <= t_in;
				y_s           <= y_in;
				big_s         <= big_in;
				hn_s_s[h+1]   <= sv + tsntp_pkg::poly_coef(h);
				hn_t_s[h+1]   <= t_s;
				hn_y_s[h+1]   <= y_s;
				hn_big_s[h+1] <= big_s;
			end
		end
	end

	// exp(-y) by Taylor series
	logic [tsntp_pkg::T_W-1:0]          tc_term_s [1:TN];
	logic signed [tsntp_pkg::ACC_W-1:0] tc_acc_s  [1:TN];
	logic [tsntp_pkg::Y_W-1:0]          tc_y_s    [1:TN];
	logic [tsntp_pkg::S_W-2:0]          tc_p_s    [1:TN];
	logic                               tc_big_s  [1:TN];

	for (genvar k = 1; k <= TN; k++) begin : g_term
		localparam logic [tsntp_pkg::RCP_W-1:0] RCP =
			tsntp_pkg::RCP_W'((64'd1 << tsntp_pkg::RCP_SH) / k);
		localparam logic [tsntp_pkg::V_W-1:0] BIAS = tsntp_pkg::V_W'(k / 2);
		localparam int MT_W = tsntp_pkg::T_W + tsntp_pkg::Y_W;
		localparam int E_W  = tsntp_pkg::V_W + tsntp_pkg::RCP_W;

		logic [tsntp_pkg::T_W-1:0]          term_in;
		logic signed [tsntp_pkg::ACC_W-1:0] acc_in;
		logic [tsntp_pkg::Y_W-1:0]          y_in;
		logic [tsntp_pkg::S_W-2:0]          p_in;
		logic                               big_in;

		logic [MT_W-1:0]                    ma_s;
		logic signed [tsntp_pkg::ACC_W-1:0] acc_a_s, acc_b_s, acc_c;
		logic [tsntp_pkg::Y_W-1:0]          y_a_s, y_b_s;
		logic [tsntp_pkg::S_W-2:0]          p_a_s, p_b_s;
		logic                               big_a_s, big_b_s;
		logic [tsntp_pkg::V_W-1:0]          v_c, v_b_s;
		logic [E_W-1:0]                     est_b_s;
		logic [tsntp_pkg::RCP_W-1:0]        q0;
		logic [tsntp_pkg::RCP_W+3:0]        qk;
		logic [tsntp_pkg::V_W-1:0]          rem_c;
		logic [tsntp_pkg::T_W-1:0]          q_c;

		if (k == 1) begin : g_first
			logic signed [tsntp_pkg::S_W-1:0] sfin;
			assign sfin    = hn_s_s[PN];
			assign term_in = tsntp_pkg::T_W'(tsntp_pkg::ONE_Q32);
			assign acc_in  = tsntp_pkg::ACC_W'(tsntp_pkg::ONE_Q32);
			assign y_in    = hn_y_s[PN];
			assign p_in    = sfin[tsntp_pkg::S_W-1] ? '0 : sfin[tsntp_pkg::S_W-2:0];
			assign big_in  = hn_big_s[PN];
		end else begin : g_next
			assign term_in = tc_term_s[k-1];
			assign acc_in  = tc_acc_s[k-1];
			assign y_in    = tc_y_s[k-1];
			assign p_in    = tc_p_s[k-1];
			assign big_in  = tc_big_s[k-1];
		end

		assign v_c   = tsntp_pkg::V_W'((ma_s + MT_W'(tsntp_pkg::HALF)) >> 32) + BIAS;
		assign q0    = tsntp_pkg::RCP_W'(est_b_s >> tsntp_pkg::RCP_SH);
		assign qk    = q0 * (tsntp_pkg::RCP_W+4)'(k);
		assign rem_c = v_b_s - tsntp_pkg::V_W'(qk);
		assign q_c   = (rem_c >= tsntp_pkg::V_W'(k)) ? tsntp_pkg::T_W'(q0 + 1'b1)
		                                            : tsntp_pkg::T_W'(q0);
		assign acc_c = (k % 2 == 1) ? acc_b_s - $signed({2'b00, q_c})
		                            : acc_b_s + $signed({2'b00, q_c});

		always_ff @(posedge clk) begin
			if (adv) begin
				ma_s         <= term_in * y_in;
				acc_a_s      <= acc_in;
				y_a_s        <= y_in;
				p_a_s        <= p_in;
				big_a_s      <= big_in;
				v_b_s        <= v_c;
				est_b_s      <= v_c * RCP;
				acc_b_s      <= acc_a_s;
				y_b_s        <= y_a_s;
				p_b_s        <= p_a_s;
				big_b_s      <= big_a_s;
				tc_term_s[k] <= q_c;
				tc_acc_s[k]  <= acc_c;
				tc_y_s[k]    <= y_b_s;
				tc_p_s[k]    <= p_b_s;
				tc_big_s[k]  <= big_b_s;
			end
		end
	end

	// square six times to undo y = x/64
	logic [tsntp_pkg::T_W-1:0] sq_e_s   [1:HN];
	logic [tsntp_pkg::S_W-2:0] sq_p_s   [1:HN];
	logic                      sq_big_s [1:HN];

	for (genvar q = 0; q < HN; q++) begin : g_sq
		localparam int SQ_W = 2 * tsntp_pkg::T_W;
		logic [tsntp_pkg::T_W-1:0] e_in;
		logic [tsntp_pkg::S_W-2:0] p_in, p_a_s;
		logic                      big_in, big_a_s;
		logic [SQ_W-1:0]           m_s;

		if (q == 0) begin : g_first
			logic signed [tsntp_pkg::ACC_W-1:0] acc;
			assign acc    = tc_acc_s[TN];
			assign e_in   = acc[tsntp_pkg::ACC_W-1] ? '0 :
			                (64'(acc) > tsntp_pkg::ONE_Q32) ? tsntp_pkg::T_W'(tsntp_pkg::ONE_Q32) :
			                tsntp_pkg::T_W'(acc);
			assign p_in   = tc_p_s[TN];
			assign big_in = tc_big_s[TN];
		end else begin : g_next
			assign e_in   = sq_e_s[q];
			assign p_in   = sq_p_s[q];
			assign big_in = sq_big_s[q];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				m_s           <= e_in * e_in;
				p_a_s         <= p_in;
				big_a_s       <= big_in;
				sq_e_s[q+1]   <= tsntp_pkg::T_W'((m_s + SQ_W'(tsntp_pkg::HALF)) >> 32);
				sq_p_s[q+1]   <= p_a_s;
				sq_big_s[q+1] <= big_a_s;
			end
		end
	end

	// polynomial times exp, round to output and saturate; force zero when a >= 6
	logic [M_W-1:0]            fm_s, fr_c, res_c;
	logic                      big_f_s;
	logic [tsntp_pkg::P_W-1:0] prob_q;

	assign fr_c  = (fm_s + M_W'(tsntp_pkg::HALF)) >> 32;
	assign res_c = (fr_c + M_W'(tsntp_pkg::RND_OUT)) >> tsntp_pkg::OUT_SH;

	always_ff @(posedge clk) begin
		if (adv) begin
			fm_s    <= sq_p_s[HN] * sq_e_s[HN];
			big_f_s <= sq_big_s[HN];
			if (big_f_s) begin
				prob_q <= '0;
			end else if (64'(res_c) > tsntp_pkg::P_ONE) begin
				prob_q <= tsntp_pkg::P_W'(tsntp_pkg::P_ONE);
			end else begin
				prob_q <= tsntp_pkg::P_W'(res_c);
			end
		end
	end

	assign tail_probability = prob_q;

endmodule
